### src/wnm_pkg.sv
// shared types, character codes and helpers for the wildcard name matcher
`default_nettype none

package wnm_pkg;

    localparam int PATTERN_LEN = 32;

    localparam logic [15:0] CH_STAR    = 16'h002A;
    localparam logic [15:0] CH_QUEST   = 16'h003F;
    localparam logic [15:0] CH_LOWER_A = 16'h0061;
    localparam logic [15:0] CH_LOWER_Z = 16'h007A;
    localparam logic [15:0] FOLD_DELTA = 16'h007A - 16'h005A;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_NAME   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic        step;
        logic        feed;
        logic        clear;
        logic        append;
        logic [15:0] fc;
    } cell_ctrl_t;

    // result word: verdict and overflow flag
    typedef struct packed {
        logic overflow;
        logic matched;
    } result_t;

    function automatic logic [15:0] fold_upper(input logic [15:0] c);
        logic [15:0] r;
        r = c;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            r = c - FOLD_DELTA;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/wildcard_name_matcher.sv
// top level: row of pattern cells, overflow flag and result buffer
//
// Matches names against a wildcard pattern of up to 32 characters ('*' any run, '?' any one
// character, a-z folded to upper case). A word of any command may be accepted on every clock
// edge while the two-entry result buffer has room. The verdict for an end-of-name word is
// written into the result buffer as the word is accepted. The clock rate is set by the star
// closure, which ripples combinationally through the row of cells.
`default_nettype none

module wildcard_name_matcher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] ch
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] matched, [1] pattern_overflow, rest zero
);

    localparam int LEN = wnm_pkg::PATTERN_LEN;

    wnm_pkg::cmd_t       cmd;
    wnm_pkg::cell_ctrl_t ctrl;
    wnm_pkg::result_t    res;
    wnm_pkg::result_t    head;
    logic                fire;
    logic                is_end;
    logic                full;

    logic [LEN-1:0] valid_w;
    logic [LEN-1:0] fwd_w;
    logic [LEN-1:0] close_w;
    logic [LEN-1:0] hit_w;
    logic [LEN-1:0] prev_valid;
    logic [LEN-1:0] prev_fwd;
    logic [LEN-1:0] prev_close;
    logic [LEN-1:0] act_init;

    logic tail_reg;
    logic tail_next;
    logic overflow_reg;
    logic overflow_next;

    always_comb
    begin
        cmd      = wnm_pkg::cmd_t'(s_tuser);
        s_tready = ~full;
        fire     = s_tvalid & s_tready;

        ctrl.step   = fire;
        ctrl.feed   = 1'b0;
        ctrl.clear  = 1'b0;
        ctrl.append = 1'b0;
        is_end      = 1'b0;
        ctrl.fc     = wnm_pkg::fold_upper(s_tdata);
        unique case (cmd)
            wnm_pkg::CMD_CLEAR:  ctrl.clear  = fire;
            wnm_pkg::CMD_APPEND: ctrl.append = fire;
            wnm_pkg::CMD_NAME:   ctrl.feed   = fire;
            wnm_pkg::CMD_END:    is_end      = fire;
            default:             is_end      = 1'b0;
        endcase

        // neighbour links; cell zero sees an always loaded predecessor
        prev_valid = {valid_w[LEN-2:0], 1'b1};
        prev_fwd   = {fwd_w[LEN-2:0], 1'b0};
        prev_close = {close_w[LEN-2:0], 1'b0};
        act_init   = {{(LEN-1){1'b0}}, 1'b1};

        // position past the last cell
        tail_next = (ctrl.feed & fwd_w[LEN-1]) | close_w[LEN-1];

        overflow_next = overflow_reg;
        if (ctrl.clear)
        begin
            overflow_next = 1'b0;
        end
        else if (ctrl.append & valid_w[LEN-1])
        begin
            overflow_next = 1'b1;
        end

        res.matched  = (|hit_w) | (tail_reg & valid_w[LEN-1]);
        res.overflow = overflow_reg;

        m_tdata = {6'd0, head.overflow, head.matched};
    end

    for (genvar i = 0; i < LEN; i++)
    begin : g_cell
        wnm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .act_init   (act_init[i]),
            .prev_valid (prev_valid[i]),
            .prev_fwd   (prev_fwd[i]),
            .prev_close (prev_close[i]),
            .valid      (valid_w[i]),
            .fwd        (fwd_w[i]),
            .close      (close_w[i]),
            .end_hit    (hit_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg     <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else if (fire)
        begin
            tail_reg     <= tail_next;
            overflow_reg <= overflow_next;
        end
    end

    wnm_out_fifo u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (is_end),
        .wr_data  (res),
        .full     (full),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (head)
    );

endmodule

`default_nettype wire

### src/wnm_cell.sv
// one pattern position: stored character, loaded flag and active flag
`default_nettype none

module wnm_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire wnm_pkg::cell_ctrl_t     ctrl,
    input  wire logic                    act_init,
    input  wire logic                    prev_valid,
    input  wire logic                    prev_fwd,
    input  wire logic                    prev_close,
    output logic                         valid,
    output logic                         fwd,
    output logic                         close,
    output logic                         end_hit
);

    logic [15:0] pat_reg;
    logic [15:0] pat_next;
    logic        valid_reg;
    logic        valid_next;
    logic        act_reg;
    logic        is_star;
    logic        base;
    logic        closed;

    always_comb
    begin
        is_star = (pat_reg == wnm_pkg::CH_STAR);
        // character consumed here moves the active flag on to the neighbour
        fwd = act_reg & valid_reg & ~is_star
            & ((pat_reg == wnm_pkg::CH_QUEST) | (pat_reg == ctrl.fc));
        end_hit = act_reg & prev_valid & ~valid_reg;
        valid = valid_reg;

        valid_next = valid_reg;
        pat_next   = pat_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.append)
        begin
            valid_next = valid_reg | prev_valid;
            if (prev_valid & ~valid_reg)
            begin
                pat_next = ctrl.fc;
            end
        end

        if (ctrl.feed)
        begin
            base = (act_reg & valid_reg & is_star) | prev_fwd;
        end
        else
        begin
            base = act_init;
        end

        // star closure ripples along the row like a carry
        closed = base | prev_close;
        close  = closed & valid_next & (pat_next == wnm_pkg::CH_STAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            act_reg   <= act_init;
        end
        else if (ctrl.step)
        begin
            valid_reg <= valid_next;
            act_reg   <= closed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            pat_reg <= pat_next;
        end
    end

endmodule

`default_nettype wire

### src/wnm_out_fifo.sv
// two-entry result buffer between the cell row and the output side
`default_nettype none

module wnm_out_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire wnm_pkg::result_t    wr_data,
    output logic                     full,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output wnm_pkg::result_t         rd_data
);

    wnm_pkg::result_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       rd_en;

    always_comb
    begin
        full     = (cnt_reg == 2'd2);
        rd_valid = (cnt_reg != 2'd0);
        rd_en    = rd_valid & rd_ready;
        rd_data  = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### src/wnm_checker.sv
// port-level checks for the wildcard name matcher, bound to the top level
`default_nettype none

module wnm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    // input held off only while results are waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // an end-of-name word always yields a result
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == wnm_pkg::CMD_END) |=> m_tvalid)
        else $error("end of name gave no result");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("result padding not zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### sim/wildcard_name_matcher_tb.sv
// testbench for the wildcard name matcher: random patterns and names checked against a predictor
`timescale 1ns / 1ps

module wildcard_name_matcher_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_WORDS  = 150;

    typedef struct {
        wnm_pkg::cmd_t cmd;
        logic [15:0]   ch;
    } word_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'd0;
    logic [1:0]  s_tuser  = wnm_pkg::CMD_CLEAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // pattern store and automaton state of the predictor
    logic [15:0]                   pat_chars [wnm_pkg::PATTERN_LEN];
    int                            pat_len;
    logic [wnm_pkg::PATTERN_LEN:0] live;
    logic                          ovf_seen;

    word_t            stim_q [$];
    wnm_pkg::result_t verdicts_due [$];

    int  words_queued   = 0;
    int  words_sent     = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_asks      = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;
    logic s_took        = 1'b0;

    wildcard_name_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [15:0] upper_of(input logic [15:0] c);
        if (c >= 16'h0061 && c <= 16'h007A)
        begin
            return c - 16'h0020;
        end
        return c;
    endfunction

    // a live star also makes the next position live, rippling forward
    task automatic close_stars();
        for (int i = 0; i < pat_len; i++)
        begin
            if (live[i] && pat_chars[i] == wnm_pkg::CH_STAR)
            begin
                live[i + 1] = 1'b1;
            end
        end
    endtask

    task automatic rearm_live();
        live    = '0;
        live[0] = 1'b1;
        close_stars();
    endtask

    task automatic step_name(input logic [15:0] c);
        logic [wnm_pkg::PATTERN_LEN:0] nxt;
        logic [15:0]                   fc;
        nxt = '0;
        fc  = upper_of(c);
        for (int i = 0; i < pat_len; i++)
        begin
            if (live[i])
            begin
                if (pat_chars[i] == wnm_pkg::CH_STAR)
                begin
                    nxt[i] = 1'b1;
                end
                else if (pat_chars[i] == wnm_pkg::CH_QUEST || upper_of(pat_chars[i]) == fc)
                begin
                    nxt[i + 1] = 1'b1;
                end
            end
        end
        live = nxt;
        close_stars();
    endtask

    task automatic predict_word(input wnm_pkg::cmd_t cmd, input logic [15:0] ch);
        wnm_pkg::result_t r;
        case (cmd)
            wnm_pkg::CMD_CLEAR:
            begin
                pat_len  = 0;
                ovf_seen = 1'b0;
                rearm_live();
            end
            wnm_pkg::CMD_APPEND:
            begin
                if (pat_len < wnm_pkg::PATTERN_LEN)
                begin
                    pat_chars[pat_len] = ch;
                    pat_len++;
                end
                else
                begin
                    ovf_seen = 1'b1;
                end
                rearm_live();
            end
            wnm_pkg::CMD_NAME:
            begin
                step_name(ch);
            end
            default:
            begin
                r.matched  = live[pat_len];
                r.overflow = ovf_seen;
                verdicts_due.push_back(r);
                rearm_live();
            end
        endcase
    endtask

    task automatic add_word(input wnm_pkg::cmd_t cmd, input logic [15:0] ch);
        word_t w;
        w.cmd = cmd;
        w.ch  = ch;
        stim_q.push_back(w);
        words_queued++;
    endtask

    // characters near the fold range edges, wildcards, and now and then any code
    function automatic logic [15:0] pat_char();
        case ($urandom_range(0, 11))
            0, 1:    return wnm_pkg::CH_STAR;
            2:       return wnm_pkg::CH_QUEST;
            3:       return 16'($urandom_range(0, 65535));
            4:       return 16'h0060;
            5:       return 16'h007B;
            6:       return wnm_pkg::CH_LOWER_A;
            7:       return wnm_pkg::CH_LOWER_Z;
            8:       return 16'h0041;
            9:       return 16'h005A;
            10:      return 16'h0000;
            default: return 16'h0062;
        endcase
    endfunction

    function automatic logic [15:0] name_char();
        if ($urandom_range(0, 9) == 0)
        begin
            return 16'($urandom_range(0, 65535));
        end
        return pat_char();
    endfunction

    // clear, load a pattern, then feed names mostly built to fit it
    task automatic gen_group(input int max_names);
        logic [15:0] pch [40];
        logic [15:0] c;
        int          plen;
        int          kept;
        int          skip;
        case ($urandom_range(0, 19))
            0, 1:    plen = $urandom_range(33, 40);
            2:       plen = 0;
            default: plen = $urandom_range(1, 8);
        endcase
        add_word(wnm_pkg::CMD_CLEAR, 16'($urandom_range(0, 65535)));
        for (int i = 0; i < plen; i++)
        begin
            pch[i] = pat_char();
            add_word(wnm_pkg::CMD_APPEND, pch[i]);
        end
        kept = (plen > wnm_pkg::PATTERN_LEN) ? wnm_pkg::PATTERN_LEN : plen;
        for (int n = $urandom_range(1, max_names); n > 0; n--)
        begin
            // now and then drop one position, or add a stray character at the end
            skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, kept) : -1;
            for (int i = 0; i < kept; i++)
            begin
                if (i == skip)
                begin
                    continue;
                end
                if (pch[i] == wnm_pkg::CH_STAR)
                begin
                    repeat ($urandom_range(0, 3)) add_word(wnm_pkg::CMD_NAME, name_char());
                end
                else if (pch[i] == wnm_pkg::CH_QUEST)
                begin
                    add_word(wnm_pkg::CMD_NAME, name_char());
                end
                else
                begin
                    c = pch[i];
                    if ($urandom_range(0, 1) == 1)
                    begin
                        if (c >= 16'h0061 && c <= 16'h007A)
                        begin
                            c = c - 16'h0020;
                        end
                        else if (c >= 16'h0041 && c <= 16'h005A)
                        begin
                            c = c + 16'h0020;
                        end
                    end
                    add_word(wnm_pkg::CMD_NAME, c);
                end
            end
            if (skip == kept)
            begin
                add_word(wnm_pkg::CMD_NAME, name_char());
            end
            if ($urandom_range(0, 15) == 0)
            begin
                add_word(wnm_pkg::cmd_t'($urandom_range(0, 3)),
                         16'($urandom_range(0, 65535)));
            end
            add_word(wnm_pkg::CMD_END, 16'($urandom_range(0, 65535)));
        end
    endtask

    // wait until every queued word has gone in and every verdict has come back
    task automatic drain();
        while (words_sent != words_queued)
        begin
            @(negedge clk);
        end
        while (verdicts_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        word_t w;
        if (rst_n && (!s_tvalid || s_took))
        begin
            if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                w = stim_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= w.ch;
                s_tuser  <= w.cmd;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_served)
        begin
            hold_left   <= LONG_HOLD;
            hold_served <= hold_asks;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_left != 0)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: check verdict words, predict on accepted input words
    always @(posedge clk)
    begin
        wnm_pkg::result_t exp_r;
        if (!rst_n)
        begin
            s_took <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual %02h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    exp_r = verdicts_due.pop_front();
                    if (m_tdata[0] !== exp_r.matched)
                    begin
                        $display("%0t: matched expected %0b actual %0b",
                                 $time, exp_r.matched, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[1] !== exp_r.overflow)
                    begin
                        $display("%0t: pattern_overflow expected %0b actual %0b",
                                 $time, exp_r.overflow, m_tdata[1]);
                        mismatches++;
                    end
                    if (m_tdata[7:2] !== 6'd0)
                    begin
                        $display("%0t: padding expected 00 actual %02h",
                                 $time, m_tdata[7:2]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_word(wnm_pkg::cmd_t'(s_tuser), s_tdata);
                words_sent++;
            end
            s_took <= s_tvalid && s_tready;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int start;
        int send_pct [3];
        int recv_pct [3];
        send_pct = '{51, 0, 16};
        recv_pct = '{0, 51, 16};

        for (int i = 0; i < wnm_pkg::PATTERN_LEN; i++)
        begin
            pat_chars[i] = 16'd0;
        end
        pat_len  = 0;
        ovf_seen = 1'b0;
        rearm_live();

        // directed: empty pattern and name, lone star, case folding, code zero
        add_word(wnm_pkg::CMD_END, 16'h0000);
        add_word(wnm_pkg::CMD_NAME, wnm_pkg::CH_LOWER_A);
        add_word(wnm_pkg::CMD_END, 16'hFFFF);
        add_word(wnm_pkg::CMD_APPEND, wnm_pkg::CH_STAR);
        add_word(wnm_pkg::CMD_END, 16'h0000);
        add_word(wnm_pkg::CMD_NAME, 16'hFFFF);
        add_word(wnm_pkg::CMD_NAME, 16'h0000);
        add_word(wnm_pkg::CMD_END, 16'h0000);
        add_word(wnm_pkg::CMD_CLEAR, 16'hFFFF);
        add_word(wnm_pkg::CMD_APPEND, wnm_pkg::CH_LOWER_A);
        add_word(wnm_pkg::CMD_APPEND, wnm_pkg::CH_QUEST);
        add_word(wnm_pkg::CMD_NAME, 16'h0041);
        add_word(wnm_pkg::CMD_NAME, 16'h0000);
        add_word(wnm_pkg::CMD_END, 16'h0000);
        add_word(wnm_pkg::CMD_APPEND, wnm_pkg::CH_LOWER_Z);
        add_word(wnm_pkg::CMD_NAME, 16'h0041);
        add_word(wnm_pkg::CMD_NAME, 16'h0078);
        add_word(wnm_pkg::CMD_NAME, 16'h005A);
        add_word(wnm_pkg::CMD_END, 16'h0000);
        add_word(wnm_pkg::CMD_NAME, 16'h007B);
        add_word(wnm_pkg::CMD_END, 16'h0000);
        add_word(wnm_pkg::CMD_CLEAR, 16'h0000);
        add_word(wnm_pkg::CMD_APPEND, 16'h0000);
        add_word(wnm_pkg::CMD_NAME, 16'h0000);
        add_word(wnm_pkg::CMD_END, 16'h0000);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first phase with no idling on either side
        start = words_queued;
        while (words_queued - start < PHASE_WORDS)
        begin
            gen_group(4);
        end
        drain();

        // receiver holds off while the sender keeps pushing end words
        hold_asks++;
        repeat (20) add_word(wnm_pkg::CMD_END, 16'($urandom_range(0, 65535)));
        gen_group(6);
        gen_group(6);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            start = words_queued;
            while (words_queued - start < PHASE_WORDS)
            begin
                gen_group(4);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
